// ===== hdl/matrix_inverse_4x4_assert.svh =====
// Assertion macros for the 4x4 matrix inverse checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MATRIX_INVERSE_4X4_ASSERT_SVH
`define MATRIX_INVERSE_4X4_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MI4_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MI4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mi4_pkg.sv =====
// Shared types, widths and helper functions for the 4x4 matrix inverse.
// No dependencies.
`default_nettype none
package mi4_pkg;
	localparam int ELEM_W    = 32;
	localparam int IDX_W     = 4;
	localparam int MAG_W     = 96;           // adjugate magnitude
	localparam int ADJ_W     = MAG_W + 1;
	localparam int ACC_W     = 98;           // signed adjugate accumulator
	localparam int TERM_W    = 128;
	localparam int DET_W     = 131;
	localparam int NUM_W     = 128;
	localparam int Q_W       = 33;
	localparam int BIT_CNT_W = 7;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam logic [2:0] LAST_TERM = 3'd5;
	localparam logic [2:0] NEG_TERM  = 3'd3;
	localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		idx_t  idx;
		elem_t value;
	} tok_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} adj_t;

	typedef struct packed {
		elem_t value;
		idx_t  idx;
		logic  last;
		logic  sing;
	} res_t;

	function automatic logic [ELEM_W-1:0] mag32(input elem_t v);
		return v[ELEM_W-1] ? ELEM_W'(-v) : ELEM_W'(v);
	endfunction

	// Map a 0..2 position onto 0..3 while skipping one index.
	function automatic logic [1:0] pick(input logic [1:0] n, input logic [1:0] skip);
		return (n >= skip) ? 2'(n + 2'd1) : n;
	endfunction

	// Column taken from minor row n in triple-product term t.
	function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] n);
		logic [5:0] p;
		case (t)
			3'd0: p = {2'd2, 2'd1, 2'd0};
			3'd1: p = {2'd0, 2'd2, 2'd1};
			3'd2: p = {2'd1, 2'd0, 2'd2};
			3'd3: p = {2'd0, 2'd1, 2'd2};
			3'd4: p = {2'd2, 2'd0, 2'd1};
			3'd5: p = {2'd1, 2'd2, 2'd0};
			default: p = {2'd2, 2'd1, 2'd0};
		endcase
		return p[{n, 1'b0} +: 2];
	endfunction
endpackage
`default_nettype wire

// ===== hdl/mi4_if.sv =====
// Valid/ready channel interfaces for matrix elements and inverse results.
// Depends on mi4_pkg.
`default_nettype none
interface mi4_elem_if;
	logic          valid;
	logic          ready;
	mi4_pkg::elem_t elem_value;
	modport source(output valid, output elem_value, input ready);
	modport sink(input valid, input elem_value, output ready);
endinterface

interface mi4_inv_if;
	logic           valid;
	logic           ready;
	mi4_pkg::elem_t inv_value;
	mi4_pkg::idx_t  inv_index;
	logic           last_elem;
	logic           singular;
	modport source(output valid, output inv_value, output inv_index, output last_elem,
		output singular, input ready);
	modport sink(input valid, input inv_value, input inv_index, input last_elem,
		input singular, output ready);
endinterface
`default_nettype wire

// ===== hdl/mi4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mi4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/mi4_front.sv =====
// Front end: accepts elements, sign-extends each from its low VALUE_WIDTH
// bits and tags it with its row-major position. Depends on mi4_pkg.
`default_nettype none
module mi4_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire mi4_pkg::elem_t   in_value,
	output logic                  in_ready,
	output logic                  push,
	output mi4_pkg::tok_t         push_tok,
	input  wire mi4_pkg::q_stat_t stat
);
	import mi4_pkg::*;

	localparam int EW = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
	localparam int SH = ELEM_W - EW;

	idx_t  load_cnt_q;
	elem_t shl;

	assign in_ready = !stat.full;
	assign push     = in_valid && in_ready;
	assign shl      = in_value <<< SH;

	always_comb begin
		push_tok.idx   = load_cnt_q;
		push_tok.value = shl >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (push) begin
			load_cnt_q <= load_cnt_q + 4'd1;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/mi4_queue.sv =====
// Short token queue between the front end and the compute engine.
// Depends on mi4_pkg.
`default_nettype none
module mi4_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mi4_pkg::tok_t push_tok,
	input  wire logic          pop,
	output mi4_pkg::tok_t      head,
	output mi4_pkg::q_stat_t   stat
);
	import mi4_pkg::*;

	tok_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign head       = mem_q[rptr_q];
	assign stat.full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/mi4_back.sv =====
// Compute engine: stores the matrix, builds adjugate and determinant with a
// shared 32x32 multiplier, divides bit-serially and drives the result register.
// Depends on mi4_pkg and mi4_ram.
`default_nettype none
module mi4_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mi4_pkg::tok_t    head,
	input  wire mi4_pkg::q_stat_t stat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mi4_pkg::res_t         out_res
);
	import mi4_pkg::*;

	localparam int EW = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
	localparam logic [Q_W-1:0] LIM_POS = Q_W'((64'd1 << (EW - 1)) - 64'd1);
	localparam logic [Q_W-1:0] LIM_NEG = Q_W'(64'd1 << (EW - 1));

	typedef enum logic [21:0] {
		S_LOAD = 22'h000001, S_RA   = 22'h000002, S_RB   = 22'h000004,
		S_RC   = 22'h000008, S_M1   = 22'h000010, S_M2   = 22'h000020,
		S_M3   = 22'h000040, S_M4   = 22'h000080, S_ACC  = 22'h000100,
		S_WADJ = 22'h000200, S_DA   = 22'h000400, S_DB   = 22'h000800,
		S_DM0  = 22'h001000, S_DM1  = 22'h002000, S_DM2  = 22'h004000,
		S_DM3  = 22'h008000, S_DACC = 22'h010000, S_DABS = 22'h020000,
		S_QA   = 22'h040000, S_QB   = 22'h080000, S_QDIV = 22'h100000,
		S_QOUT = 22'h200000
	} state_t;

	state_t               state_q;
	idx_t                 ent_q;
	logic [2:0]           term_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic                 out_valid_q;
	res_t                 out_q;

	elem_t               xa_q, xb_q;
	logic [ELEM_W-1:0]   xc_q, hi_q;
	logic [63:0]         mul_q;
	logic [TERM_W-1:0]   prod_q;
	logic [ACC_W-1:0]    acc_q;
	logic                sgn_q;
	adj_t                adj_q;
	logic [DET_W-1:0]    det_q, dmag_q;
	logic                dneg_q, sing_q, qneg_q, big_q;
	logic [NUM_W-1:0]    num_q;
	logic [DET_W-1:0]    rem_q;
	logic [Q_W-1:0]      quo_q;

	logic              mat_we;
	logic [3:0]        mat_raddr;
	elem_t             mat_rdata;
	logic              adj_we;
	logic [3:0]        adj_raddr;
	adj_t              adj_rdata;
	adj_t              adj_wr;
	logic [ELEM_W-1:0] mul_a, mul_b;
	logic [1:0]        r_sel, c_sel, n_sel;
	logic              out_free;
	logic [DET_W:0]    trial;
	logic [DET_W+1:0]  diff;
	logic              ge;
	logic [Q_W-1:0]    lim, qs, sv;

	assign r_sel     = ent_q[3:2];
	assign c_sel     = ent_q[1:0];
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == S_LOAD) && !stat.empty;
	assign mat_we    = pop;
	assign adj_we    = (state_q == S_WADJ);
	assign adj_wr.neg = acc_q[ACC_W-1];
	assign adj_wr.mag = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);

	always_comb begin
		case (state_q)
			S_RB:    n_sel = 2'd1;
			S_RC:    n_sel = 2'd2;
			default: n_sel = 2'd0;
		endcase
		// minor of row c and column r, term columns permuted per term index
		mat_raddr = {pick(n_sel, c_sel), pick(perm_col(term_q, n_sel), r_sel)};
		adj_raddr = ent_q;
		if (state_q == S_DA) begin
			mat_raddr = {2'd0, ent_q[1:0]};
			adj_raddr = {ent_q[1:0], 2'd0};
		end
	end

	always_comb begin
		case (state_q)
			S_M1:    begin mul_a = mag32(xa_q);   mul_b = mag32(xb_q); end
			S_M2:    begin mul_a = mul_q[31:0];   mul_b = xc_q; end
			S_M3:    begin mul_a = hi_q;          mul_b = xc_q; end
			S_DM0:   begin mul_a = mag32(xa_q);   mul_b = adj_q.mag[31:0]; end
			S_DM1:   begin mul_a = mag32(xa_q);   mul_b = adj_q.mag[63:32]; end
			S_DM2:   begin mul_a = mag32(xa_q);   mul_b = adj_q.mag[95:64]; end
			default: begin mul_a = '0;            mul_b = '0; end
		endcase
	end

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dmag_q};
	assign ge    = !diff[DET_W+1];
	assign lim   = qneg_q ? LIM_NEG : LIM_POS;
	assign qs    = (big_q || quo_q > lim) ? lim : quo_q;
	assign sv    = qneg_q ? (~qs + 1'b1) : qs;

	mi4_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (head.idx),
		.wdata (head.value),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	mi4_ram #(.WIDTH(ADJ_W), .DEPTH(16)) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (ent_q),
		.wdata (adj_wr),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// datapath
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			S_LOAD: begin
				acc_q <= '0;
			end
			S_RB: xa_q <= mat_rdata;
			S_RC: xb_q <= mat_rdata;
			S_M1: begin
				xc_q  <= mag32(mat_rdata);
				sgn_q <= xa_q[ELEM_W-1] ^ xb_q[ELEM_W-1] ^ mat_rdata[ELEM_W-1]
					^ (term_q >= NEG_TERM) ^ r_sel[0] ^ c_sel[0];
			end
			S_M2: hi_q <= mul_q[63:32];
			S_M3: prod_q <= TERM_W'(mul_q);
			S_M4: prod_q <= prod_q + {32'd0, mul_q, 32'd0};
			S_ACC: acc_q <= sgn_q ? acc_q - prod_q[ACC_W-1:0] : acc_q + prod_q[ACC_W-1:0];
			S_WADJ: begin
				acc_q <= '0;
				det_q <= '0;
			end
			S_DB: begin
				xa_q  <= mat_rdata;
				adj_q <= adj_rdata;
			end
			S_DM0: sgn_q <= xa_q[ELEM_W-1] ^ adj_q.neg;
			S_DM1: prod_q <= TERM_W'(mul_q);
			S_DM2: prod_q <= prod_q + {32'd0, mul_q, 32'd0};
			S_DM3: prod_q <= prod_q + {mul_q, 64'd0};
			S_DACC: begin
				det_q <= sgn_q ? det_q - DET_W'(prod_q) : det_q + DET_W'(prod_q);
			end
			S_DABS: begin
				dneg_q <= det_q[DET_W-1];
				dmag_q <= det_q[DET_W-1] ? (~det_q + 1'b1) : det_q;
				sing_q <= (det_q == '0);
			end
			S_QB: begin
				num_q  <= {adj_rdata.mag, 32'd0};
				qneg_q <= adj_rdata.neg ^ dneg_q;
				rem_q  <= '0;
				quo_q  <= '0;
				big_q  <= 1'b0;
			end
			S_QDIV: begin
				rem_q <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
				big_q <= big_q | quo_q[Q_W-1];
				quo_q <= {quo_q[Q_W-2:0], ge};
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
			S_QOUT: begin
				if (out_free) begin
					out_q.value <= sing_q ? '0 : elem_t'(sv[ELEM_W-1:0]);
					out_q.idx   <= ent_q;
					out_q.last  <= (ent_q == LAST_IDX);
					out_q.sing  <= sing_q;
				end
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			ent_q       <= '0;
			term_q      <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the item once taken, unless a new one is loaded this cycle
			if (out_valid_q && out_ready && (state_q != S_QOUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (pop && head.idx == LAST_IDX) begin
						ent_q   <= '0;
						term_q  <= '0;
						state_q <= S_RA;
					end
				end
				S_RA:  state_q <= S_RB;
				S_RB:  state_q <= S_RC;
				S_RC:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_M3;
				S_M3:  state_q <= S_M4;
				S_M4:  state_q <= S_ACC;
				S_ACC: begin
					if (term_q == LAST_TERM) begin
						state_q <= S_WADJ;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= S_RA;
					end
				end
				S_WADJ: begin
					term_q <= '0;
					if (ent_q == LAST_IDX) begin
						ent_q   <= '0;
						state_q <= S_DA;
					end else begin
						ent_q   <= ent_q + 4'd1;
						state_q <= S_RA;
					end
				end
				S_DA:  state_q <= S_DB;
				S_DB:  state_q <= S_DM0;
				S_DM0: state_q <= S_DM1;
				S_DM1: state_q <= S_DM2;
				S_DM2: state_q <= S_DM3;
				S_DM3: state_q <= S_DACC;
				S_DACC: begin
					if (ent_q[1:0] == 2'd3) begin
						ent_q   <= '0;
						state_q <= S_DABS;
					end else begin
						ent_q   <= ent_q + 4'd1;
						state_q <= S_DA;
					end
				end
				S_DABS: state_q <= S_QA;
				S_QA:   state_q <= S_QB;
				S_QB: begin
					bit_cnt_q <= BIT_CNT_W'(NUM_W - 1);
					state_q   <= sing_q ? S_QOUT : S_QDIV;
				end
				S_QDIV: begin
					if (bit_cnt_q == '0) begin
						state_q <= S_QOUT;
					end else begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
					end
				end
				S_QOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (ent_q == LAST_IDX) begin
							ent_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							ent_q   <= ent_q + 4'd1;
							state_q <= S_QA;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
endmodule
`default_nettype wire

// ===== hdl/matrix_inverse_4x4.sv =====
// 4x4 matrix inverse, Q16.16, cofactor/adjugate with exact division.
// Elements are taken at one per cycle through a 4-entry queue while the engine
// loads, until the queue fills; after the 16th, the engine builds the adjugate
// (triple products on the shared multiplier), then the determinant, then each
// result in the bit-serial divider; a singular matrix skips the division.
// Reset clears counters, queue, engine state and output valid; stores are not cleared.
`default_nettype none
module matrix_inverse_4x4 #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mi4_elem_if.sink  elem,
	mi4_inv_if.source inv
);
	import mi4_pkg::*;

	logic    push, pop, in_ready, out_valid;
	tok_t    push_tok, head;
	q_stat_t stat;
	res_t    out_res;

	assign elem.ready = in_ready;

	mi4_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (elem.valid),
		.in_value (elem.elem_value),
		.in_ready (in_ready),
		.push     (push),
		.push_tok (push_tok),
		.stat     (stat)
	);

	mi4_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	mi4_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (inv.ready),
		.out_res   (out_res)
	);

	assign inv.valid     = out_valid;
	assign inv.inv_value = out_res.value;
	assign inv.inv_index = out_res.idx;
	assign inv.last_elem = out_res.last;
	assign inv.singular  = out_res.sing;
endmodule
`default_nettype wire

// ===== hdl/mi4_checker.sv =====
// Port-level checks on the inverse result channel, bound to the top level.
// Depends on mi4_pkg and matrix_inverse_4x4_assert.svh.
`default_nettype none
`include "matrix_inverse_4x4_assert.svh"
module mi4_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           inv_valid,
	input wire logic           inv_ready,
	input wire mi4_pkg::elem_t inv_value,
	input wire mi4_pkg::idx_t  inv_index,
	input wire logic           last_elem,
	input wire logic           singular
);
	`MI4_ASSERT_NEXT(a_valid_hold, inv_valid && !inv_ready, inv_valid, "result dropped while stalled")
	`MI4_ASSERT_NEXT(a_data_hold, inv_valid && !inv_ready, $stable(inv_value) && $stable(inv_index) && $stable(last_elem) && $stable(singular), "result changed while stalled")
	`MI4_ASSERT_NEXT(a_index_seq, inv_valid && inv_ready && !last_elem, !inv_valid || inv_index == $past(inv_index) + 4'd1, "result index out of sequence")
	`MI4_ASSERT_NOW(a_sing_zero, inv_valid && singular, inv_value == '0 && (last_elem == (inv_index == 4'd15)), "singular result not zero or bad last flag")
endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.inv_valid (inv.valid),
	.inv_ready (inv.ready),
	.inv_value (inv.inv_value),
	.inv_index (inv.inv_index),
	.last_elem (inv.last_elem),
	.singular  (inv.singular)
);
`default_nettype wire

// ===== tb/matrix_inverse_4x4_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 4x4 matrix inverse: collects elements, predicts the inverse
// exactly from cofactors, and compares every result item. Depends on mi4_pkg, mi4_if.
`default_nettype none
module matrix_inverse_4x4_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	mi4_elem_if       elem,
	mi4_inv_if        inv,
	output int        pending,
	output int        errors
);
	import mi4_pkg::*;

	typedef logic signed [191:0] wide_t;

	elem_t  mat [16];
	int     load_cnt;
	res_t   inv_expected [$];

	function automatic wide_t minor3(input int skip_r, input int skip_c);
		int    rs [3];
		int    cs [3];
		int    n;
		wide_t a [3][3];
		wide_t pos;
		wide_t neg;
		n = 0;
		for (int k = 0; k < 4; k++) if (k != skip_r) begin rs[n] = k; n++; end
		n = 0;
		for (int k = 0; k < 4; k++) if (k != skip_c) begin cs[n] = k; n++; end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = mat[rs[i] * 4 + cs[j]];
		pos = a[0][0] * a[1][1] * a[2][2] + a[0][1] * a[1][2] * a[2][0]
			+ a[0][2] * a[1][0] * a[2][1];
		neg = a[0][2] * a[1][1] * a[2][0] + a[0][1] * a[1][0] * a[2][2]
			+ a[0][0] * a[1][2] * a[2][1];
		return pos - neg;
	endfunction

	task automatic predict_inverse();
		wide_t       adj [16];
		wide_t       det;
		logic [191:0] num_mag;
		logic [191:0] det_mag;
		logic [191:0] quo;
		logic [191:0] lim;
		logic        neg;
		logic        sing;
		res_t        r;
		for (int row = 0; row < 4; row++)
			for (int col = 0; col < 4; col++) begin
				adj[row * 4 + col] = ((row + col) % 2 == 1) ? -minor3(col, row) : minor3(col, row);
			end
		det = 0;
		for (int k = 0; k < 4; k++) det = det + wide_t'(mat[k]) * adj[k * 4];
		sing = (det == 0);
		det_mag = det[191] ? -det : det;
		for (int k = 0; k < 16; k++) begin
			r.value = '0;
			if (!sing) begin
				neg = adj[k][191] != det[191];
				num_mag = adj[k][191] ? -adj[k] : adj[k];
				quo = (num_mag << 32) / det_mag;
				lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
				if (quo > lim) quo = lim;
				r.value = neg ? elem_t'(-quo[31:0]) : elem_t'(quo[31:0]);
			end
			r.idx  = idx_t'(k);
			r.last = (k == 15);
			r.sing = sing;
			inv_expected.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			load_cnt = 0;
			errors   = 0;
			inv_expected.delete();
		end else begin
			if (elem.valid && elem.ready) begin
				mat[load_cnt] = elem.elem_value;
				load_cnt++;
				if (load_cnt == 16) begin
					load_cnt = 0;
					predict_inverse();
				end
			end
			if (inv.valid && inv.ready) begin
				if (inv_expected.size() == 0) begin
					errors++;
					if (errors <= 10) $display("%0t: unexpected result item idx %0d value %h",
						$realtime, inv.inv_index, inv.inv_value);
				end else begin
					want = inv_expected.pop_front();
					if (inv.inv_value !== want.value || inv.inv_index !== want.idx
						|| inv.last_elem !== want.last || inv.singular !== want.sing) begin
						errors++;
						if (errors <= 10) $display(
							"%0t: mismatch exp val %h idx %0d last %b sing %b, got %h %0d %b %b",
							$realtime, want.value, want.idx, want.last, want.sing,
							inv.inv_value, inv.inv_index, inv.last_elem, inv.singular);
					end
				end
			end
		end
		pending = inv_expected.size();
	end
endmodule
`default_nettype wire

// ===== tb/matrix_inverse_4x4_tb.sv =====
`timescale 1ns / 1ps
// Top of the 4x4 matrix inverse testbench: clock, reset, element stimulus and
// result back-pressure. Depends on mi4_pkg, mi4_if and matrix_inverse_4x4_checker.
`default_nettype none
module matrix_inverse_4x4_tb;
	import mi4_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   pending;
	int   errors;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   hold_seq;
	int   hold_seen;
	int   hold_left;

	mi4_elem_if elem ();
	mi4_inv_if  inv ();

	matrix_inverse_4x4 u_dut (.clk(clk), .arst_n(arst_n), .elem(elem), .inv(inv));

	matrix_inverse_4x4_checker u_chk (.clk(clk), .arst_n(arst_n), .elem(elem), .inv(inv),
		.pending(pending), .errors(errors));

	always #1 clk = ~clk;

	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv.ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_left > 0) begin
			inv.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seq != hold_seen) begin
			inv.ready <= 1'b0;
			hold_seen <= hold_seq;
			hold_left <= 4000;
		end else begin
			inv.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_elem(input elem_t v);
		if ($urandom_range(99) < send_idle_pct) begin
			elem.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		elem.valid      <= 1'b1;
		elem.elem_value <= v;
		do @(posedge clk); while (!elem.ready);
	endtask

	task automatic send_matrix(input elem_t m [16]);
		for (int k = 0; k < 16; k++) send_elem(m[k]);
	endtask

	function automatic elem_t rand_elem(input int kind);
		if (kind == 0) return elem_t'($urandom);
		return elem_t'(int'($urandom_range(262143)) - 131072);
	endfunction

	initial begin
		elem_t m [16];
		int    kind;
		elem.valid      = 1'b0;
		elem.elem_value = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_seq        = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity in Q16.16
		for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sh0001_0000 : '0;
		send_matrix(m);
		// tiny determinant: saturate both ways
		for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sd1 : '0;
		m[5] = -32'sd1;
		send_matrix(m);
		// all zeros: singular
		for (int k = 0; k < 16; k++) m[k] = '0;
		send_matrix(m);
		// field extremes
		for (int k = 0; k < 16; k++)
			m[k] = (k % 3 == 0) ? 32'sh8000_0000 : (k % 3 == 1) ? 32'sh7FFF_FFFF : -32'sd1;
		m[0] = 32'sh7FFF_FFFF;
		send_matrix(m);

		for (int n = 0; n < 11; n++) begin
			case ((n / 3) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			if (n == 2) hold_seq <= hold_seq + 1;
			if (n == 6) begin
				elem.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			kind = $urandom_range(99);
			for (int k = 0; k < 16; k++) m[k] = rand_elem(kind < 30 ? 0 : 1);
			// duplicated row forces a singular matrix
			if (kind >= 85)
				for (int c = 0; c < 4; c++) m[8 + c] = m[c];
			send_matrix(m);
		end
		elem.valid <= 1'b0;
		recv_stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/mi4_pkg.sv
hdl/mi4_if.sv
hdl/mi4_ram.sv
hdl/mi4_front.sv
hdl/mi4_queue.sv
hdl/mi4_back.sv
hdl/matrix_inverse_4x4.sv
hdl/mi4_checker.sv
tb/matrix_inverse_4x4_checker.sv
tb/matrix_inverse_4x4_tb.sv
